### rtl/tssg_pkg.sv
// shared types, constants and the quarter-wave cosine table of the sine/square generator
package tssg_pkg;

  localparam int TABLE_BITS = 8;
  localparam int TABLE_N = 1 << TABLE_BITS;
  localparam int IDX_W = TABLE_BITS + 1;

  localparam int PERIOD_W = 16;
  localparam int TIME_W = 32;
  localparam int FRAC_W = 16;
  localparam int LEVEL_W = 17;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // integer bits of the quotient, then the fraction bits
  localparam int DIV_STEPS = TIME_W + FRAC_W;
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  localparam logic FUNC_COSINE = 1'b0;
  localparam logic FUNC_SQUARE = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } tssg_cmd_t;

  typedef struct packed {
    logic skip_div;
    logic out_free;
  } tssg_stat_t;

  typedef logic [LEVEL_W-1:0] cos_tab_t [0:TABLE_N];

  // cos(pi/2 * k / N) in Q1.16, Taylor series in Q30, evaluated at elaboration
  function automatic cos_tab_t cos_table();
    cos_tab_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] q;
    longint sum;
    for (int k = 0; k <= TABLE_N; k++) begin
      x = (64'(k) * PI_Q30) >> (TABLE_BITS + 1);
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      sum = longint'(term);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q = (64'(sum) + (64'd1 << 13)) >> 14;
      if (q > 64'(ONE_Q16)) begin
        q = 64'(ONE_Q16);
      end
      tab[k] = q[LEVEL_W-1:0];
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = cos_table();

endpackage

### rtl/tssg_ctrl.sv
// sequencer: accepts a word, runs the bit-serial divide unless it is skipped, hands the result to the output register
module tssg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  tssg_pkg::tssg_stat_t stat,
  output tssg_pkg::tssg_cmd_t  cmd
);
  import tssg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.skip_div) begin
          state_next = ST_FIN;
        end else begin
          cmd.step = 1'b1;
          cnt_next = cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.emit}))
    else $error("more than one datapath command at once");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result written while output register still full");

  a_load_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_DIV) && (cnt == '0))
    else $error("accepted word did not start the divide");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    cmd.step && (cnt == CNT_LAST) |=> (state == ST_FIN))
    else $error("divide did not finish after the last step");
`endif

endmodule

### rtl/tssg_datapath.sv
// period and start-time registers, restoring divider, cosine lookup and output register
module tssg_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [tssg_pkg::PERIOD_W-1:0] cfg_wr_data,
  input  logic [tssg_pkg::TIME_W-1:0]   now_ms,
  input  logic                         func,
  input  tssg_pkg::tssg_cmd_t          cmd,
  output tssg_pkg::tssg_stat_t         stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tssg_pkg::LEVEL_W-1:0]  level
);
  import tssg_pkg::*;

  logic [PERIOD_W-1:0] period;
  logic [TIME_W-1:0]   start_time;
  logic [TIME_W-1:0]   elapsed;
  logic                func_q;
  logic [TIME_W-1:0]   dividend;
  logic [PERIOD_W:0]   rem;
  logic [FRAC_W-1:0]   frac;

  logic [TIME_W-1:0]   elapsed_now;
  logic [PERIOD_W:0]   rem_sh;
  logic                rem_ge;
  logic [1:0]          quad;
  logic [TABLE_BITS-1:0] idx;
  logic [IDX_W-1:0]    tab_idx;
  logic [LEVEL_W-1:0]  mag;
  logic                neg;
  logic [LEVEL_W:0]    rc_sum;
  logic [LEVEL_W-1:0]  level_calc;

  assign elapsed_now = now_ms - start_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
      start_time <= '0;
    end else begin
      if (cfg_wr_en) begin
        period <= cfg_wr_data;
      end
      // restart the period once a full one has gone by
      if (cmd.load && (elapsed_now >= TIME_W'(period))) begin
        start_time <= now_ms;
      end
    end
  end

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign rem_sh = {rem[PERIOD_W-1:0], dividend[TIME_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, period});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elapsed <= elapsed_now;
      dividend <= elapsed_now;
      func_q <= func;
      rem <= '0;
      frac <= '0;
    end else if (cmd.step) begin
      dividend <= {dividend[TIME_W-2:0], 1'b0};
      rem <= rem_ge ? (rem_sh - {1'b0, period}) : rem_sh;
      frac <= {frac[FRAC_W-2:0], rem_ge};
    end
  end

  assign stat = '{skip_div: (func_q == FUNC_SQUARE) || (period == '0),
                  out_free: !out_valid || out_ready};

  // quarter-wave lookup, mirrored in quadrants one and three
  assign quad = frac[FRAC_W-1:FRAC_W-2];
  assign idx = frac[FRAC_W-3 -: TABLE_BITS];
  assign tab_idx = (quad[0]) ? (IDX_W'(TABLE_N) - {1'b0, idx}) : {1'b0, idx};
  assign mag = COS_TAB[tab_idx];
  assign neg = (quad == 2'd1) || (quad == 2'd2);
  assign rc_sum = neg ? ({1'b0, ONE_Q16} + {1'b0, mag}) : ({1'b0, ONE_Q16} - {1'b0, mag});

  always_comb begin
    if (func_q == FUNC_SQUARE) begin
      level_calc = ({elapsed, 1'b0} >= (TIME_W+1)'(period)) ? ONE_Q16 : '0;
    end else begin
      level_calc = rc_sum[LEVEL_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      level <= level_calc;
    end
  end

endmodule

### rtl/timed_sine_square_generator_top.sv
// top level of the timed raised-cosine / square generator
//
// input stream: s_axis_tdata carries now_ms (32 bits), s_axis_tuser selects the
// waveform (0 raised cosine, 1 square). output stream: m_axis_tdata carries level
// in Q1.16 (0 to 65536). cfg_wr_en/cfg_wr_data write period_ms; write it only
// while no query is in flight.
// one query at a time: s_axis_tready is high only between queries. a raised
// cosine query runs a restoring divide of elapsed time by the period, one
// quotient bit per cycle, 32 integer plus 16 fraction bits; its result is
// written to the output register once the last bit is in and that register
// is free, and the next word is taken after that. square queries and a zero
// period skip the divide.
// the result sits in an output register, so the block takes the next query
// while the receiver stalls; a new result waits in the sequencer until that
// register is free.
// reset: period_ms returns to 1000, the start time to 0, both streams idle.
module timed_sine_square_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] now_ms
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [16:0] level, [23:17] zero
);
  import tssg_pkg::*;

  tssg_cmd_t  cmd;
  tssg_stat_t stat;
  logic [LEVEL_W-1:0] level;

  tssg_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  tssg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .now_ms      (s_axis_tdata),
    .func        (s_axis_tuser),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .level       (level)
  );

  assign m_axis_tdata = {7'b0, level};

endmodule

### tb/tb_timed_sine_square_generator_top.sv
// testbench for the timed raised-cosine / square generator, checked against its own predictor
`timescale 1ns / 1ps

module tb_timed_sine_square_generator_top;
  import tssg_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic [31:0] now_ms;
    logic        func;
  } query_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] now_ms
  logic        s_axis_tuser = 1'b0; // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [16:0] level, [23:17] zero

  logic [16:0] cos_q16 [0:TABLE_N];
  logic [15:0] period_cfg = PERIOD_RESET;
  logic [31:0] start_ms = '0;
  logic [31:0] gen_ms = '0;
  query_t      query_q [$];
  logic [16:0] levels_q [$];
  query_t      next_query;
  logic [16:0] new_level;
  logic [16:0] want_level;
  logic        idle_on = 1'b1;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  timed_sine_square_generator_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // cos(pi/2 * k / N) in Q1.16 via a 9-term Taylor series in Q30
  function automatic logic [16:0] quarter_cos(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    longint      acc;
    x = (64'(k) * PI_Q30) >> (TABLE_BITS + 1);
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    acc = longint'(term);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (64'(acc) + (64'd1 << 13)) >> 14;
    if (r > 64'(ONE_Q16)) begin
      r = 64'(ONE_Q16);
    end
    return r[16:0];
  endfunction

  task automatic predict_level(input logic [31:0] now, input logic func,
                               output logic [16:0] level);
    logic [31:0] elapsed;
    logic [63:0] rem;
    logic [15:0] frac;
    int          idx;
    logic [16:0] mag;
    logic        neg;
    elapsed = now - start_ms;
    frac = '0;
    if (func == FUNC_SQUARE) begin
      level = (({1'b0, elapsed} << 1) >= 33'(period_cfg)) ? ONE_Q16 : '0;
    end else begin
      // zero period keeps the fraction at zero
      if (period_cfg != 0) begin
        rem = 64'(elapsed % 32'(period_cfg));
        frac = 16'((rem << 16) / 64'(period_cfg));
      end
      idx = int'(frac[13:0] >> (14 - TABLE_BITS));
      case (frac[15:14])
        2'd0: begin
          mag = cos_q16[idx];
          neg = 1'b0;
        end
        2'd1: begin
          mag = cos_q16[TABLE_N - idx];
          neg = 1'b1;
        end
        2'd2: begin
          mag = cos_q16[idx];
          neg = 1'b1;
        end
        default: begin
          mag = cos_q16[TABLE_N - idx];
          neg = 1'b0;
        end
      endcase
      level = neg ? 17'((18'(ONE_Q16) + 18'(mag)) >> 1) : 17'((18'(ONE_Q16) - 18'(mag)) >> 1);
    end
    if (elapsed >= 32'(period_cfg)) begin
      start_ms = now;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("ERROR at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_query(input logic [31:0] now, input logic func);
    query_t q;
    q.now_ms = now;
    q.func = func;
    query_q.push_back(q);
  endtask

  // wait until no word is queued, offered or owed, then let the block settle
  task automatic wait_idle(input int settle);
    while (query_q.size() != 0 || s_axis_tvalid || levels_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] value);
    wait_idle(4);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    period_cfg = value;
  endtask

  // time mostly moves forward by up to a few periods, with jumps and wraps mixed in
  task automatic gen_phase(input int count, input logic [15:0] p);
    int          r;
    int unsigned span;
    span = (p == 0) ? 1000 : int'(p);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        gen_ms = $urandom;
      end else if (r == 1) begin
        gen_ms = 32'hFFFF_FFFF - $urandom_range(0, span);
      end else if (r < 5) begin
        gen_ms = gen_ms + $urandom_range(0, 3 * span);
      end else begin
        gen_ms = gen_ms + $urandom_range(0, span);
      end
      add_query(gen_ms, 1'($urandom_range(0, 1)));
    end
  endtask

  // query driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        tx_gap <= $urandom_range(0, 13);
        s_axis_tvalid <= 1'b0;
      end else if (query_q.size() != 0) begin
        next_query = query_q.pop_front();
        s_axis_tdata <= next_query.now_ms;
        s_axis_tuser <= next_query.func;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_gap <= 0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // predict on every accepted query word
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_level(s_axis_tdata, s_axis_tuser, new_level);
      levels_q.push_back(new_level);
    end
  end

  // check every accepted level word
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (levels_q.size() == 0) begin
        report_mismatch("unexpected level word", m_axis_tdata, '0);
      end else begin
        want_level = levels_q.pop_front();
        if (m_axis_tdata[16:0] != want_level) begin
          report_mismatch("level", 24'(m_axis_tdata[16:0]), 24'(want_level));
        end
        if (m_axis_tdata[23:17] != '0) begin
          report_mismatch("pad bits", 24'(m_axis_tdata[23:17]), '0);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [15:0] p;
    for (int k = 0; k <= TABLE_N; k++) begin
      cos_q16[k] = quarter_cos(k);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset period: quadrant edges, square threshold, reload, phase above one, wrap
    add_query(32'd0, FUNC_COSINE);
    add_query(32'd250, FUNC_COSINE);
    add_query(32'd500, FUNC_COSINE);
    add_query(32'd499, FUNC_SQUARE);
    add_query(32'd500, FUNC_SQUARE);
    add_query(32'd999, FUNC_COSINE);
    add_query(32'd1000, FUNC_COSINE);
    add_query(32'd4500, FUNC_SQUARE);
    add_query(32'd7250, FUNC_COSINE);
    add_query(32'hFFFF_FFFF, FUNC_COSINE);
    add_query(32'd5, FUNC_SQUARE);
    add_query(32'd5, FUNC_COSINE);

    write_period(16'd1);
    add_query(32'd10, FUNC_COSINE);
    add_query(32'd10, FUNC_SQUARE);
    add_query(32'd11, FUNC_COSINE);
    add_query(32'd11, FUNC_SQUARE);

    write_period(16'hFFFF);
    add_query(32'd100, FUNC_COSINE);
    add_query(32'd32867, FUNC_COSINE);
    add_query(32'd65634, FUNC_SQUARE);
    add_query(32'd65636, FUNC_COSINE);

    // zero period: fraction forced to zero, square always high, always reloads
    write_period(16'd0);
    add_query(32'd7, FUNC_COSINE);
    add_query(32'd8, FUNC_SQUARE);
    add_query(32'h8000_0000, FUNC_COSINE);
    add_query(32'd9, FUNC_SQUARE);

    gen_ms = 32'd9;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: p = 16'd1;
        1: p = 16'hFFFF;
        2: p = 16'd2;
        3: p = 16'd1000;
        4: p = 16'($urandom_range(1, 64));
        5: p = 16'($urandom_range(1, 65535));
        6: p = 16'($urandom_range(3, 300));
        default: p = 16'($urandom_range(1, 2000));
      endcase
      write_period(p);
      if (ph == 7) begin
        idle_on <= 1'b0;
      end
      gen_phase(104, p);
    end

    wait_idle(60);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
